// File: hw/rtl/rltx_pkg.sv
// shared types, constants and functions of the run length texture unit
package rltx_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int PIXEL_BITS      = 8;
   localparam int FEATURE_BITS    = 4;
   localparam int CENTER_ROW_BITS = 12;
   localparam int CENTER_COL_BITS = 10;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(640);
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(480);

   // register index, taken from paddr bit 2
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;

   typedef logic [1:0] run_class_type;

   // runs in one window row
   localparam run_class_type CLASS_SOLID = 2'd0;
   localparam run_class_type CLASS_PAIR  = 2'd1;
   localparam run_class_type CLASS_SPLIT = 2'd2;

   typedef struct packed {
      run_class_type [2:0]        row_class;
      logic [CENTER_ROW_BITS-1:0] center_row;
      logic [CENTER_COL_BITS-1:0] center_col;
      logic                       last_of_frame;
   } queue_entry_type;

   function automatic run_class_type run_class(input logic [PIXEL_BITS-1:0] a,
                                               input logic [PIXEL_BITS-1:0] b,
                                               input logic [PIXEL_BITS-1:0] c);
      run_class_type cls;
      if (a == b && b == c) begin
         cls = CLASS_SOLID;
      end else if (a == b || b == c) begin
         cls = CLASS_PAIR;
      end else begin
         cls = CLASS_SPLIT;
      end
      return cls;
   endfunction

   // floor(sum of squared run lengths / run count), set by the class counts
   function automatic logic [FEATURE_BITS-1:0] run_feature(input run_class_type [2:0] cls);
      logic [1:0]              n_solid;
      logic [1:0]              n_pair;
      logic [FEATURE_BITS-1:0] f;
      n_solid = 2'd0;
      n_pair  = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (cls[i] == CLASS_SOLID) n_solid = n_solid + 2'd1;
         if (cls[i] == CLASS_PAIR)  n_pair  = n_pair + 2'd1;
      end
      unique case ({n_solid, n_pair})
         {2'd3, 2'd0}: f = FEATURE_BITS'(9);
         {2'd2, 2'd1}: f = FEATURE_BITS'(5);
         {2'd2, 2'd0}: f = FEATURE_BITS'(4);
         {2'd1, 2'd2}: f = FEATURE_BITS'(3);
         {2'd1, 2'd1}: f = FEATURE_BITS'(2);
         {2'd1, 2'd0}: f = FEATURE_BITS'(2);
         {2'd0, 2'd3}: f = FEATURE_BITS'(2);
         default:      f = FEATURE_BITS'(1);
      endcase
      return f;
   endfunction

endpackage

// File: hw/rtl/rltx_ram.sv
// generic single write port ram with registered read
module rltx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rltx_front.sv
// front end: raster counters, line stores, 3x3 window and row run classification
module rltx_front #(
   parameter int MAX_WIDTH  = rltx_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rltx_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [rltx_pkg::PIXEL_BITS-1:0]      pixel,
   input  logic                                 restart,
   input  logic [rltx_pkg::WIDTH_REG_BITS-1:0]  cfg_width,
   input  logic [rltx_pkg::HEIGHT_REG_BITS-1:0] cfg_height,
   output logic                                 busy,
   output logic                                 entry_valid,
   output rltx_pkg::queue_entry_type            entry
);
   import rltx_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int WX = (WW > WIDTH_REG_BITS) ? WW : WIDTH_REG_BITS;
   localparam int HX = (HW > HEIGHT_REG_BITS) ? HW : HEIGHT_REG_BITS;

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [WX-1:0] w_raw;
   logic [HX-1:0] h_raw;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic          col_last, row_last;

   logic                       valid_b_ff, valid_b_in;
   logic [PIXEL_BITS-1:0]      pixel_b_ff;
   logic [CB-1:0]              addr_b_ff;
   logic                       interior_b_ff;
   logic [CENTER_ROW_BITS-1:0] crow_b_ff;
   logic [CENTER_COL_BITS-1:0] ccol_b_ff;
   logic                       last_b_ff;

   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [PIXEL_BITS-1:0] upper_q, middle_q;

   assign w_raw = WX'(cfg_width);
   assign h_raw = HX'(cfg_height);

   always_comb begin
      priority if (w_raw < WX'(3)) begin
         w_eff = WW'(3);
      end else if (w_raw > WX'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_raw);
      end
      priority if (h_raw < HX'(3)) begin
         h_eff = HW'(3);
      end else if (h_raw > HX'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(h_raw);
      end
   end

   assign col_last = (WW'(col_ff) == w_eff - WW'(1));
   assign row_last = (HW'(row_ff) == h_eff - HW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RB'(1);
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   assign valid_b_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         valid_b_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_b_ff    <= pixel;
         addr_b_ff     <= col_ff;
         interior_b_ff <= (row_ff >= RB'(2)) && (col_ff >= CB'(2));
         crow_b_ff     <= CENTER_ROW_BITS'(row_ff - RB'(1));
         ccol_b_ff     <= CENTER_COL_BITS'(col_ff - CB'(1));
         last_b_ff     <= col_last && row_last;
      end
   end

   rltx_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
   ) u_upper (
      .clock  (clock),
      .wr_en  (valid_b_ff),
      .wr_addr(addr_b_ff),
      .wr_data(middle_q),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(upper_q)
   );

   rltx_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
   ) u_middle (
      .clock  (clock),
      .wr_en  (valid_b_ff),
      .wr_addr(addr_b_ff),
      .wr_data(pixel_b_ff),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(middle_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (valid_b_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= upper_q;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= middle_q;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= pixel_b_ff;
      end
   end

   assign busy        = valid_b_ff;
   assign entry_valid = valid_b_ff && interior_b_ff;

   always_comb begin
      entry.row_class[0] = run_class(win_ff[0], win_ff[1], upper_q);
      entry.row_class[1] = run_class(win_ff[2], win_ff[3], middle_q);
      entry.row_class[2] = run_class(win_ff[4], win_ff[5], pixel_b_ff);
      entry.center_row    = crow_b_ff;
      entry.center_col    = ccol_b_ff;
      entry.last_of_frame = last_b_ff;
   end

endmodule

// File: hw/rtl/rltx_queue.sv
// short queue of classified windows between front and back
module rltx_queue #(
   parameter int DEPTH = rltx_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  rltx_pkg::queue_entry_type      push_data,
   input  logic                           pop,
   output rltx_pkg::queue_entry_type      pop_data,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import rltx_pkg::*;

   localparam int PB = $clog2(DEPTH);
   localparam int NB = $clog2(DEPTH + 1);

   queue_entry_type slots_ff [DEPTH];
   logic [PB-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + NB'(1);
         2'b01:   count_in = count_ff - NB'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slots_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// File: hw/rtl/rltx_back.sv
// back end: feature lookup and result register
module rltx_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  rltx_pkg::queue_entry_type            q_data,
   output logic                                 q_pop,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic [rltx_pkg::FEATURE_BITS-1:0]    rsp_feature,
   output logic [rltx_pkg::CENTER_ROW_BITS-1:0] rsp_center_row,
   output logic [rltx_pkg::CENTER_COL_BITS-1:0] rsp_center_col,
   output logic                                 rsp_last_of_frame
);
   import rltx_pkg::*;

   logic                       out_valid_ff, out_valid_in;
   logic [FEATURE_BITS-1:0]    feature_ff;
   logic [CENTER_ROW_BITS-1:0] row_ff;
   logic [CENTER_COL_BITS-1:0] col_ff;
   logic                       last_ff;
   logic                       taken;

   assign taken        = out_valid_ff && rsp_pop;
   assign q_pop        = !q_empty && (!out_valid_ff || taken);
   assign out_valid_in = q_pop || (out_valid_ff && !taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         feature_ff <= run_feature(q_data.row_class);
         row_ff     <= q_data.center_row;
         col_ff     <= q_data.center_col;
         last_ff    <= q_data.last_of_frame;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_feature       = feature_ff;
   assign rsp_center_row    = row_ff;
   assign rsp_center_col    = col_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

// File: hw/rtl/run_length_texture_3x3_unit.sv
// top level of the 3x3 run length texture unit
// throughput: one pixel per cycle unless req_full; the line stores are read at
//   acceptance and written back the next cycle, so consecutive pixels never wait
//   on each other; path: a result leaves the front in the cycle after acceptance
//   and reaches the result ports through a queue slot and the result register
// reset: synchronous; clears counters, window, queue and result register and sets
//   width 640, height 480; line stores are not cleared and need no clearing pass
module run_length_texture_3x3_unit #(
   parameter int MAX_WIDTH  = rltx_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rltx_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [rltx_pkg::PIXEL_BITS-1:0]      req_pixel,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [rltx_pkg::FEATURE_BITS-1:0]    rsp_feature,
   output logic [rltx_pkg::CENTER_ROW_BITS-1:0] rsp_center_row,
   output logic [rltx_pkg::CENTER_COL_BITS-1:0] rsp_center_col,
   output logic                                 rsp_last_of_frame,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rltx_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rltx_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rltx_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import rltx_pkg::*;

   localparam int NB = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic                       csr_write;
   logic                       accept;
   logic                       front_busy;
   logic                       entry_valid;
   queue_entry_type            entry;
   queue_entry_type            q_data;
   logic                       q_empty;
   logic                       q_pop;
   logic [NB-1:0]              q_count;
   logic [NB:0]                in_flight;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WIDTH:  width_in  = csr_pwdata[WIDTH_REG_BITS-1:0];
            REG_HEIGHT: height_in = csr_pwdata[HEIGHT_REG_BITS-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // room is reserved for the transaction still in the front stage
   assign in_flight = (NB+1)'(q_count) + (NB+1)'(front_busy);
   assign req_full  = (in_flight >= (NB+1)'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;

   rltx_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel      (req_pixel),
      .restart    (csr_write),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .busy       (front_busy),
      .entry_valid(entry_valid),
      .entry      (entry)
   );

   rltx_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_valid),
      .push_data(entry),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty),
      .count    (q_count)
   );

   rltx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_feature      (rsp_feature),
      .rsp_center_row   (rsp_center_row),
      .rsp_center_col   (rsp_center_col),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

endmodule

// File: hw/rtl/rltx_checker.sv
// port level checks of the run length texture unit and their bind
module rltx_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [rltx_pkg::FEATURE_BITS-1:0]    rsp_feature,
   input logic [rltx_pkg::CENTER_ROW_BITS-1:0] rsp_center_row,
   input logic [rltx_pkg::CENTER_COL_BITS-1:0] rsp_center_col,
   input logic                                 rsp_last_of_frame
);

   // nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // a waiting result holds until taken
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_feature)
         && $stable(rsp_center_row) && $stable(rsp_center_col)
         && $stable(rsp_last_of_frame)))
      else $error("result changed while stalled");

   // mean squared run length of a 3x3 window lies in 1..9
   a_feature_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_feature != '0 && rsp_feature <= 4'd9))
      else $error("feature out of range");

   // the left border column (column 0) never reaches the result side
   a_center_col: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_center_col != '0))
      else $error("border column produced a result");

   // the input is never reported full while no push is made and no result waits
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !req_push && $past(!req_push) && $past(!req_push, 2)
         && $past(rsp_empty)) |-> !req_full)
      else $error("input blocked while idle");

endmodule

bind run_length_texture_3x3_unit rltx_checker u_checker (.*);

// File: tb/tb_run_length_texture_3x3_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the 3x3 run length texture unit
module tb_run_length_texture_3x3_unit;
   import rltx_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH_DEFAULT;
   localparam int ROW_LIMIT  = MAX_HEIGHT_DEFAULT;
   localparam int MIN_DIM    = 3;

   typedef struct packed {
      logic [FEATURE_BITS-1:0]    feature;
      logic [CENTER_ROW_BITS-1:0] center_row;
      logic [CENTER_COL_BITS-1:0] center_col;
      logic                       last_of_frame;
   } texture_result_type;

   typedef enum int {PIX_BINARY, PIX_TERNARY, PIX_EXTREME, PIX_FULL} pixel_mix_type;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       req_full;
   logic [PIXEL_BITS-1:0]      req_pixel;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [FEATURE_BITS-1:0]    rsp_feature;
   logic [CENTER_ROW_BITS-1:0] rsp_center_row;
   logic [CENTER_COL_BITS-1:0] rsp_center_col;
   logic                       rsp_last_of_frame;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   // predictor state
   logic [WIDTH_REG_BITS-1:0]  width_reg;
   logic [HEIGHT_REG_BITS-1:0] height_reg;
   logic [PIXEL_BITS-1:0]      upper_line [LINE_DEPTH];
   logic [PIXEL_BITS-1:0]      middle_line [LINE_DEPTH];
   logic [PIXEL_BITS-1:0]      window_pix [6];
   int                         col_count;
   int                         row_count;
   texture_result_type         texture_results_due [$];

   int  errors;
   int  pixels_accepted;
   int  results_checked;
   int  frames_closed;
   int  settings_written;
   int  full_stall_cycles;
   int  hold_off_cycles;
   int  rsp_gap;
   bit  rsp_steady;
   bit  tx_steady;
   bit  tx_calm;

   run_length_texture_3x3_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel         (req_pixel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_feature       (rsp_feature),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_dim(input int v, input int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int active_width();
      return clamp_dim(int'(width_reg), LINE_DEPTH);
   endfunction

   function automatic int active_height();
      return clamp_dim(int'(height_reg), ROW_LIMIT);
   endfunction

   function automatic int runs_in_row(input logic [PIXEL_BITS-1:0] a,
                                      input logic [PIXEL_BITS-1:0] b,
                                      input logic [PIXEL_BITS-1:0] c);
      if (a == b && b == c) return 1;
      if (a == b || b == c) return 2;
      return 3;
   endfunction

   // squared run lengths of one 3-pixel row, by run count
   function automatic int run_squares(input int runs);
      case (runs)
         1: return 9;
         2: return 5;
         default: return 3;
      endcase
   endfunction

   function automatic void apply_geometry(input logic reg_index,
                                          input logic [CSR_DATA_BITS-1:0] value);
      if (reg_index == REG_WIDTH) begin
         width_reg = value[WIDTH_REG_BITS-1:0];
      end else begin
         height_reg = value[HEIGHT_REG_BITS-1:0];
      end
      col_count = 0;
      row_count = 0;
   endfunction

   function automatic void predict_texture(input logic [PIXEL_BITS-1:0] pix);
      int              w;
      int              h;
      int              col;
      int              row;
      int              sq;
      int              runs;
      int              k;
      logic [PIXEL_BITS-1:0] up;
      logic [PIXEL_BITS-1:0] mid;
      texture_result_type res;
      w = active_width();
      h = active_height();
      col = col_count;
      row = row_count;
      if (col >= w) col = w - 1;
      if (row >= h) row = h - 1;
      up = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = pix;
      if (row >= 2 && col >= 2) begin
         k = runs_in_row(window_pix[0], window_pix[1], up);
         sq = run_squares(k);
         runs = k;
         k = runs_in_row(window_pix[2], window_pix[3], mid);
         sq += run_squares(k);
         runs += k;
         k = runs_in_row(window_pix[4], window_pix[5], pix);
         sq += run_squares(k);
         runs += k;
         res.feature = FEATURE_BITS'(sq / runs);
         res.center_row = CENTER_ROW_BITS'(row - 1);
         res.center_col = CENTER_COL_BITS'(col - 1);
         res.last_of_frame = (row == h - 1 && col == w - 1);
         texture_results_due.push_back(res);
      end
      window_pix[0] = window_pix[1];
      window_pix[1] = up;
      window_pix[2] = window_pix[3];
      window_pix[3] = mid;
      window_pix[4] = window_pix[5];
      window_pix[5] = pix;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_count = col;
      row_count = row;
   endfunction

   function automatic void check_field(input string field, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
         errors++;
      end
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel(input pixel_mix_type mix);
      case (mix)
         PIX_BINARY:  return PIXEL_BITS'($urandom_range(0, 1));
         PIX_TERNARY: return PIXEL_BITS'($urandom_range(0, 2));
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:     return PIXEL_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // input transactions feed the predictor
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_texture(req_pixel);
         pixels_accepted++;
      end
      if (!reset && req_push && req_full) full_stall_cycles++;
   end

   // result transactions are compared with the oldest prediction
   always @(posedge clock) begin
      texture_result_type exp_res;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (texture_results_due.size() == 0) begin
            $error("unexpected result: feature %0d row %0d col %0d", rsp_feature,
                   rsp_center_row, rsp_center_col);
            errors++;
         end else begin
            exp_res = texture_results_due.pop_front();
            check_field("feature", exp_res.feature, rsp_feature);
            check_field("center_row", exp_res.center_row, rsp_center_row);
            check_field("center_col", exp_res.center_col, rsp_center_col);
            check_field("last_of_frame", exp_res.last_of_frame, rsp_last_of_frame);
            results_checked++;
            if (rsp_last_of_frame) frames_closed++;
         end
      end
   end

   // result side pacing
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) rsp_steady = !rsp_steady;
         if (hold_off_cycles > 0) begin
            rsp_pop <= 1'b0;
            hold_off_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_pop <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_pop <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 7) == 0) rsp_gap = pick_gap();
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      if (!tx_steady && !tx_calm && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (texture_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic read_register(input logic reg_index, output logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {reg_index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_geometry(reg_index, value);
      settings_written++;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      read_register(reg_index, readback);
      if (reg_index == REG_WIDTH) begin
         check_field("image_width", width_reg, readback);
      end else begin
         check_field("image_height", height_reg, readback);
      end
   endtask

   task automatic set_geometry(input int w, input int h);
      write_register(REG_WIDTH, CSR_DATA_BITS'(w));
      write_register(REG_HEIGHT, CSR_DATA_BITS'(h));
   endtask

   task automatic test_reset_defaults();
      logic [CSR_DATA_BITS-1:0] v;
      read_register(REG_WIDTH, v);
      check_field("image_width", WIDTH_RESET, v);
      read_register(REG_HEIGHT, v);
      check_field("image_height", HEIGHT_RESET, v);
   endtask

   // one result per 3x3 frame: solid rows, split rows, then pair rows above a solid row
   task automatic test_feature_classes();
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++) send_pixel(8'hFF);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
      for (int i = 0; i < 9; i++) send_pixel((i == 2 || i == 3) ? 8'hFF : 8'h00);
      wait_idle();
   endtask

   task automatic test_restart_on_write();
      set_geometry(5, 4);
      repeat (13) send_pixel(random_pixel(PIX_BINARY));
      wait_idle();
      write_register(REG_HEIGHT, 4);
      repeat (20) send_pixel(random_pixel(PIX_TERNARY));
      wait_idle();
      write_register(REG_WIDTH, 4);
      repeat (7) send_pixel(random_pixel(PIX_BINARY));
      wait_idle();
      write_register(REG_WIDTH, 6);
      repeat (24) send_pixel(random_pixel(PIX_TERNARY));
      wait_idle();
   endtask

   task automatic test_frame_wrap();
      set_geometry(4, 3);
      repeat (3 * 12 + 5) send_pixel(random_pixel(PIX_BINARY));
      wait_idle();
   endtask

   // receiver holds off while the sender streams, so the block fills up
   task automatic test_backpressure();
      set_geometry(3, 40);
      tx_steady = 1'b1;
      hold_off_cycles = 80;
      repeat (120) send_pixel(random_pixel(PIX_BINARY));
      tx_steady = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_frames();
      int            sent;
      int            w;
      int            h;
      int            frame_pixels;
      int            n;
      pixel_mix_type mix;
      sent = 0;
      set_geometry(MIN_DIM, MIN_DIM);
      while (sent < 350) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         case ($urandom_range(0, 3))
            0: write_register(REG_WIDTH, ($urandom << WIDTH_REG_BITS) | w);
            1: write_register(REG_HEIGHT, ($urandom << HEIGHT_REG_BITS) | h);
            default: begin
               write_register(REG_WIDTH, ($urandom << WIDTH_REG_BITS) | w);
               write_register(REG_HEIGHT, ($urandom << HEIGHT_REG_BITS) | h);
            end
         endcase
         frame_pixels = active_width() * active_height();
         n = frame_pixels * $urandom_range(0, 1) + $urandom_range(1, frame_pixels);
         mix = pixel_mix_type'($urandom_range(0, 3));
         repeat (n) send_pixel(random_pixel(mix));
         sent += n;
         wait_idle();
      end
   endtask

   // widest and tallest frames, exact and saturated settings
   task automatic test_size_extremes();
      set_geometry(2047, 0);
      repeat (40) send_pixel(random_pixel(PIX_TERNARY));
      wait_idle();
      set_geometry(LINE_DEPTH, MIN_DIM);
      repeat (20) send_pixel(random_pixel(PIX_FULL));
      wait_idle();
      set_geometry(1, 8191);
      repeat (30) send_pixel(random_pixel(PIX_BINARY));
      wait_idle();
      set_geometry(MIN_DIM, ROW_LIMIT);
      repeat (30) send_pixel(random_pixel(PIX_EXTREME));
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_pixel = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < 6; i++) window_pix[i] = '0;
      col_count = 0;
      row_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_feature_classes();
      test_restart_on_write();
      test_frame_wrap();
      test_backpressure();
      test_random_frames();
      test_size_extremes();
      wait_idle();
      repeat (10) @(posedge clock);
      if (texture_results_due.size() != 0) begin
         $error("%0d expected results never arrived", texture_results_due.size());
         errors += texture_results_due.size();
      end
      $display("covered %0d pixels over %0d register writes, %0d results checked",
               pixels_accepted, settings_written, results_checked);
      $display("%0d frames closed, input held off by a full block for %0d cycles",
               frames_closed, full_stall_cycles);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
